@@ rtl/core/extended_gcd_defines.svh @@
// ---------------------------------------------------------------------------
// Extended GCD assertion macros
// Shared property wrappers for the extended GCD core.
// ---------------------------------------------------------------------------
`ifndef EXTENDED_GCD_DEFINES_SVH
`define EXTENDED_GCD_DEFINES_SVH

// same-cycle implication, checked out of reset
`define EGCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("extended_gcd: same-cycle check failed");

// next-cycle implication, checked out of reset
`define EGCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("extended_gcd: next-cycle check failed");

`endif

@@ rtl/core/egcd_pkg.sv @@
// ---------------------------------------------------------------------------
// Extended GCD package
// Widths, transaction types, controller states and command/status structs.
// ---------------------------------------------------------------------------
package egcd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int OPND_W     = DATA_WIDTH - 1;
  localparam int COEF_W     = DATA_WIDTH;
  localparam int CNT_W      = $clog2(OPND_W);

  typedef struct packed {
    logic [OPND_W-1:0] operand_a;
    logic [OPND_W-1:0] operand_b;
  } egcd_req_t;

  typedef struct packed {
    logic        [OPND_W-1:0] gcd_value;
    logic signed [COEF_W-1:0] coeff_x;
    logic signed [COEF_W-1:0] coeff_y;
    logic                     divide_error;
  } egcd_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MULX,
    ST_MULY,
    ST_UPDATE,
    ST_FINISH
  } egcd_state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic mul_x;
    logic mul_y;
    logic update;
    logic out_load;
  } egcd_cmd_t;

  typedef struct packed {
    logic r1_zero;
    logic div_last;
  } egcd_sts_t;

endpackage

@@ rtl/core/egcd_dpath.sv @@
// ---------------------------------------------------------------------------
// Extended GCD datapath
// Remainder and coefficient registers, bit-serial restoring divider,
// shared multiplier for the coefficient updates, and the result register.
// ---------------------------------------------------------------------------
`include "extended_gcd_defines.svh"

module egcd_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  egcd_pkg::egcd_cmd_t   cmd,
  output egcd_pkg::egcd_sts_t   sts,
  input  egcd_pkg::egcd_req_t   req,
  output egcd_pkg::egcd_rsp_t   rsp
);
  import egcd_pkg::*;

  logic [OPND_W-1:0] r0;
  logic [OPND_W-1:0] r1;
  logic [COEF_W-1:0] x0;
  logic [COEF_W-1:0] x1;
  logic [COEF_W-1:0] y0;
  logic [COEF_W-1:0] y1;
  logic [COEF_W-1:0] x_new;
  logic [COEF_W-1:0] prod;
  logic              err;

  logic [OPND_W-1:0] dq;
  logic [OPND_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;

  logic [OPND_W:0]   rem_trial;
  logic [OPND_W:0]   rem_diff;
  logic              q_bit;
  logic [COEF_W-1:0] mul_b;
  logic [COEF_W-1:0] mul_res;

  assign rem_trial = {rem, dq[OPND_W-1]};
  assign rem_diff  = rem_trial - {1'b0, r1};
  assign q_bit     = (rem_trial >= {1'b0, r1});
  assign mul_b     = cmd.mul_y ? y1 : x1;
  assign mul_res   = {1'b0, dq} * mul_b;

  assign sts.r1_zero  = (r1 == '0);
  assign sts.div_last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0  <= req.operand_a;
      r1  <= req.operand_b;
      x0  <= COEF_W'(1);
      x1  <= '0;
      y0  <= '0;
      y1  <= COEF_W'(1);
      err <= (req.operand_b == '0);
    end else if (cmd.update) begin
      r0 <= r1;
      r1 <= rem;
      x0 <= x1;
      x1 <= x_new;
      y0 <= y1;
      y1 <= y0 - prod;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq  <= r0;
      rem <= '0;
      cnt <= CNT_W'(OPND_W - 1);
    end else if (cmd.div_step) begin
      dq  <= {dq[OPND_W-2:0], q_bit};
      rem <= q_bit ? rem_diff[OPND_W-1:0] : rem_trial[OPND_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_x) begin
      prod <= mul_res;
    end else if (cmd.mul_y) begin
      x_new <= x0 - prod;
      prod  <= mul_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.gcd_value    <= r0;
      rsp.coeff_x      <= x0;
      rsp.coeff_y      <= y0;
      rsp.divide_error <= err;
    end
  end

  `EGCD_ASSERT_NEXT(a_rem_below_divisor, cmd.div_step, rem < r1)
  `EGCD_ASSERT_NEXT(a_remainders_shrink, cmd.update, r1 < r0)

endmodule

@@ rtl/core/egcd_ctrl.sv @@
// ---------------------------------------------------------------------------
// Extended GCD controller
// Sequences load, divide, multiply-subtract and update steps per transaction
// and owns both handshakes.
// ---------------------------------------------------------------------------
`include "extended_gcd_defines.svh"

module egcd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output egcd_pkg::egcd_cmd_t  cmd,
  input  egcd_pkg::egcd_sts_t  sts
);
  import egcd_pkg::*;

  egcd_state_t state;
  egcd_state_t state_next;
  logic        out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_valid) state_next = ST_CHECK;
      ST_CHECK:  state_next = sts.r1_zero ? ST_FINISH : ST_DIV;
      ST_DIV:    if (sts.div_last) state_next = ST_MULX;
      ST_MULX:   state_next = ST_MULY;
      ST_MULY:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_CHECK;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      ST_CHECK:  cmd.div_init = !sts.r1_zero;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_MULX:   cmd.mul_x    = 1'b1;
      ST_MULY:   cmd.mul_y    = 1'b1;
      ST_UPDATE: cmd.update   = 1'b1;
      ST_FINISH: cmd.out_load = out_free;
      default:   cmd          = '0;
    endcase
  end

  `EGCD_ASSERT_NOW(a_no_overwrite, cmd.out_load, !rsp_valid || !rsp_stall)
  `EGCD_ASSERT_NEXT(a_accept_to_check, req_valid && !req_stall, state == ST_CHECK)

endmodule

@@ rtl/core/extended_gcd.sv @@
// ---------------------------------------------------------------------------
// Extended GCD core
// Computes gcd(a, b) with Bezout coefficients x, y (a*x + b*y = gcd);
// a zero b raises divide_error with gcd = a, x = 1, y = 0.
// ---------------------------------------------------------------------------
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  operand_a, operand_b
// rsp      out        rsp_valid/rsp_stall  gcd_value, coeff_x, coeff_y, divide_error
//
// A transaction loads the operands, then runs n Euclid steps (at most 45) before the result.
// Each step is the zero check, the bit-serial divider, then the shared multiplier
// (q*x1 then q*y1) and the update.
// Reset is synchronous and clears only the controller state and rsp_valid.
// A finished result waits in the output register; the next request is taken meanwhile.
// ---------------------------------------------------------------------------
module extended_gcd (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  egcd_pkg::egcd_req_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output egcd_pkg::egcd_rsp_t  rsp
);
  import egcd_pkg::*;

  egcd_cmd_t cmd;
  egcd_sts_t sts;

  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  egcd_dpath u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule
